// ===== rtl/cwam_pkg.sv =====
// Shared types, constants and elaboration-time table builders for the cosine unit.
// No dependencies; used by every module of the block.
`default_nettype none

package cwam_pkg;

   localparam int ANGLE_W          = 32;
   localparam int RESULT_W         = 32;
   localparam int ANGLE_FRAC_BITS  = 16;
   localparam int RESULT_FRAC_BITS = 30;
   localparam int WORK_BITS        = 32;
   localparam int ROTATION_STAGES_DEF = 24;
   localparam int MAX_STAGES       = 32;

   // pi with 60 fraction bits
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   // reduction divisors and odd quarter turns, angle units
   localparam logic [63:0] DEG_FULL = 64'd360 << ANGLE_FRAC_BITS;
   localparam logic [63:0] DEG_Q1   = 64'd90 << ANGLE_FRAC_BITS;
   localparam logic [63:0] DEG_Q3   = 64'd270 << ANGLE_FRAC_BITS;
   localparam logic [63:0] RAD_FULL =
      (64'd2 * PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
   localparam logic [63:0] RAD_Q1 =
      (PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
   localparam logic [63:0] RAD_Q3 =
      (64'd3 * PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);

   // pi/180 with 37 fraction bits
   localparam logic [63:0] DEG_K = (PI_Q60 + (64'd90 << 23)) / (64'd180 << 23);

   // working angle constants, radians with 32 fraction bits
   localparam logic [63:0] PI32      = (PI_Q60 + (64'd1 << 27)) >> 28;
   localparam logic [63:0] TWO_PI32  = (64'd2 * PI_Q60 + (64'd1 << 27)) >> 28;
   localparam logic [63:0] HALF_PI32 = (PI_Q60 + (64'd1 << 28)) >> 29;

   // magnitude of the input angle fits 32 bits (at most 2^31)
   localparam int MAG_W = 32;
   localparam int REDUCE_STEPS = $clog2(((64'd1 << 31) / RAD_FULL) + 64'd1);
   localparam int DIV_W = 33 + REDUCE_STEPS;

   localparam int RAD_W = 35;
   localparam int Z_W   = 36;
   localparam int XY_W  = 36;

   typedef struct packed {
      logic valid;
      logic degree;
      logic zero;
      logic negate;
   } ctl_type;

   // shift-subtract division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) with 62 fraction bits from the odd power series
   function automatic logic [63:0] atan_q62(input int i);
      logic [63:0] sum;
      logic [63:0] term;
      int e;
      logic done;
      sum = '0;
      done = 1'b0;
      if (i == 0) begin
         sum = PI_Q60;
      end else begin
         for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > 62) done = 1'b1;
            if (!done) begin
               term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
               if (k[0]) sum = sum - term;
               else sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] atan_entry(input int i);
      return (atan_q62(i) + (64'd1 << 29)) >> 30;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v = v_arg;
      res = '0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (bitv > v) bitv = bitv >> 2;
      end
      for (int j = 0; j < 32; j++) begin
         if (bitv != 64'd0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   // reciprocal of the rotation gain, 32 fraction bits
   function automatic logic [63:0] inv_gain(input int stages);
      logic [63:0] prod;
      prod = 64'd1 << 62;
      for (int i = 0; i < MAX_STAGES; i++) begin
         if (i < stages) prod = prod + (prod >> (2 * i));
      end
      return udiv64(64'd1 << 63, isqrt64(prod));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cwam_reduce_step.sv =====
// One restoring step of the angle remainder: compare and subtract divisor << SHIFT.
// Depends on cwam_pkg.
`default_nettype none

module cwam_reduce_step #(
   parameter int SHIFT = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cwam_pkg::ctl_type            in_ctl,
   input  logic [cwam_pkg::MAG_W-1:0]   in_rem,
   output cwam_pkg::ctl_type            out_ctl,
   output logic [cwam_pkg::MAG_W-1:0]   out_rem
);

   localparam int DW = cwam_pkg::DIV_W;
   localparam logic [DW-1:0] DEG_SH = DW'(cwam_pkg::DEG_FULL) << SHIFT;
   localparam logic [DW-1:0] RAD_SH = DW'(cwam_pkg::RAD_FULL) << SHIFT;

   logic [DW-1:0]              dsel;
   logic [DW-1:0]              rem_ext;
   logic                       take;
   logic [cwam_pkg::MAG_W-1:0] rem_in;
   logic [cwam_pkg::MAG_W-1:0] rem_ff;
   cwam_pkg::ctl_type          ctl_ff;

   always_comb begin
      dsel    = in_ctl.degree ? DEG_SH : RAD_SH;
      rem_ext = DW'(in_rem);
      take    = (rem_ext >= dsel);
      rem_in  = take ? cwam_pkg::MAG_W'(rem_ext - dsel) : in_rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign out_ctl = ctl_ff;
   assign out_rem = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/cwam_convert.sv =====
// Quarter-turn snap, degree to radian conversion and quadrant fold, four stages.
// Depends on cwam_pkg.
`default_nettype none

module cwam_convert (
   input  logic                              clock,
   input  logic                              reset,
   input  cwam_pkg::ctl_type                 in_ctl,
   input  logic [cwam_pkg::MAG_W-1:0]        in_rem,
   output cwam_pkg::ctl_type                 out_ctl,
   output logic signed [cwam_pkg::Z_W-1:0]   out_z
);

   localparam int MW = cwam_pkg::MAG_W;
   localparam int RW = cwam_pkg::RAD_W;
   localparam int ZW = cwam_pkg::Z_W;
   localparam int AF = cwam_pkg::ANGLE_FRAC_BITS;

   localparam logic [MW-1:0] DEG_Q1_M = MW'(cwam_pkg::DEG_Q1);
   localparam logic [MW-1:0] DEG_Q3_M = MW'(cwam_pkg::DEG_Q3);
   localparam logic [MW-1:0] RAD_Q1_M = MW'(cwam_pkg::RAD_Q1);
   localparam logic [MW-1:0] RAD_Q3_M = MW'(cwam_pkg::RAD_Q3);
   localparam logic [31:0]   K32      = 32'(cwam_pkg::DEG_K);
   localparam logic [63:0]   DEG_RND  = 64'd1 << (AF + 4);
   localparam logic [RW-1:0] PI_R     = RW'(cwam_pkg::PI32);
   localparam logic signed [ZW-1:0] PI_S      = ZW'(cwam_pkg::PI32);
   localparam logic signed [ZW-1:0] TWO_PI_S  = ZW'(cwam_pkg::TWO_PI32);
   localparam logic signed [ZW-1:0] HALF_PI_S = ZW'(cwam_pkg::HALF_PI32);

   // stage A: snap detect, multiply or shift
   cwam_pkg::ctl_type a_ctl_in, a_ctl_ff;
   logic [63:0]       a_mult_in, a_mult_ff;
   logic [63:0]       mult_full;

   assign mult_full = 64'(in_rem) * 64'(K32);

   always_comb begin
      a_ctl_in = in_ctl;
      if (in_ctl.degree) begin
         a_ctl_in.zero = (in_rem == DEG_Q1_M) || (in_rem == DEG_Q3_M);
         a_mult_in     = mult_full;
      end else begin
         a_ctl_in.zero = (in_rem == RAD_Q1_M) || (in_rem == RAD_Q3_M);
         a_mult_in     = 64'(in_rem) << (cwam_pkg::WORK_BITS - AF);
      end
   end

   // stage B: round the degree product to radians; radian angles pass through
   cwam_pkg::ctl_type b_ctl_ff;
   logic [RW-1:0]     b_rad_in, b_rad_ff;
   logic [63:0]       rounded;

   always_comb begin
      rounded  = (a_mult_ff + DEG_RND) >> (AF + 5);
      b_rad_in = a_ctl_ff.degree ? RW'(rounded) : RW'(a_mult_ff);
   end

   // stage C: fold (pi, 2pi) back onto [0, pi]
   cwam_pkg::ctl_type       c_ctl_ff;
   logic signed [ZW-1:0]    c_ang_in, c_ang_ff;
   logic signed [ZW-1:0]    rad_s, diff_p, diff_n;

   always_comb begin
      rad_s  = signed'(ZW'(b_rad_ff));
      diff_p = TWO_PI_S - rad_s;
      diff_n = rad_s - TWO_PI_S;
      if (b_rad_ff > PI_R) begin
         c_ang_in = diff_p[ZW-1] ? diff_n : diff_p;
      end else begin
         c_ang_in = rad_s;
      end
   end

   // stage D: fold onto [0, pi/2], mark sign flip
   cwam_pkg::ctl_type       d_ctl_in, d_ctl_ff;
   logic signed [ZW-1:0]    d_z_in, d_z_ff;

   always_comb begin
      d_ctl_in = c_ctl_ff;
      if (c_ang_ff > HALF_PI_S) begin
         d_z_in          = PI_S - c_ang_ff;
         d_ctl_in.negate = 1'b1;
      end else begin
         d_z_in          = c_ang_ff;
         d_ctl_in.negate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
         d_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= a_ctl_ff;
         c_ctl_ff <= b_ctl_ff;
         d_ctl_ff <= d_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      a_mult_ff <= a_mult_in;
      b_rad_ff  <= b_rad_in;
      c_ang_ff  <= c_ang_in;
      d_z_ff    <= d_z_in;
   end

   assign out_ctl = d_ctl_ff;
   assign out_z   = d_z_ff;

endmodule

`default_nettype wire

// ===== rtl/cwam_cordic_stage.sv =====
// One CORDIC rotation stage: shift-add micro-rotation by atan(2^-IDX).
// Depends on cwam_pkg.
`default_nettype none

module cwam_cordic_stage #(
   parameter int IDX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cwam_pkg::ctl_type                 in_ctl,
   input  logic signed [cwam_pkg::XY_W-1:0]  in_x,
   input  logic signed [cwam_pkg::XY_W-1:0]  in_y,
   input  logic signed [cwam_pkg::Z_W-1:0]   in_z,
   output cwam_pkg::ctl_type                 out_ctl,
   output logic signed [cwam_pkg::XY_W-1:0]  out_x,
   output logic signed [cwam_pkg::XY_W-1:0]  out_y,
   output logic signed [cwam_pkg::Z_W-1:0]   out_z
);

   localparam int XW = cwam_pkg::XY_W;
   localparam int ZW = cwam_pkg::Z_W;
   localparam logic signed [ZW-1:0] ATAN_C = ZW'(cwam_pkg::atan_entry(IDX));

   logic signed [XW-1:0] xs, ys;
   logic signed [XW-1:0] x_in, x_ff, y_in, y_ff;
   logic signed [ZW-1:0] z_in, z_ff;
   cwam_pkg::ctl_type    ctl_ff;

   always_comb begin
      xs = in_x >>> IDX;
      ys = in_y >>> IDX;
      if (!in_z[ZW-1]) begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ATAN_C;
      end else begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ATAN_C;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;

endmodule

`default_nettype wire

// ===== rtl/cwam_finish.sv =====
// Output stage: round x to the result format, clamp to +-1, apply sign and snap.
// Depends on cwam_pkg.
`default_nettype none

module cwam_finish (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cwam_pkg::ctl_type                    in_ctl,
   input  logic signed [cwam_pkg::XY_W-1:0]     in_x,
   output logic                                 out_strobe,
   output logic signed [cwam_pkg::RESULT_W-1:0] out_cosine
);

   localparam int XW = cwam_pkg::XY_W;
   localparam int RS = cwam_pkg::WORK_BITS - cwam_pkg::RESULT_FRAC_BITS;
   localparam logic signed [XW-1:0] HALF_LSB = XW'(64'd1 << (RS - 1));
   localparam logic signed [XW-1:0] ONE_X    = XW'(64'd1 << cwam_pkg::RESULT_FRAC_BITS);

   logic signed [XW-1:0] rounded, clamped, signed_val;
   logic signed [cwam_pkg::RESULT_W-1:0] cos_in, cos_ff;
   logic strobe_ff;

   always_comb begin
      rounded = (in_x + HALF_LSB) >>> RS;
      if (rounded > ONE_X) begin
         clamped = ONE_X;
      end else if (rounded < -ONE_X) begin
         clamped = -ONE_X;
      end else begin
         clamped = rounded;
      end
      signed_val = in_ctl.negate ? -clamped : clamped;
      cos_in     = in_ctl.zero ? '0 : cwam_pkg::RESULT_W'(signed_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
   end

   assign out_strobe = strobe_ff;
   assign out_cosine = cos_ff;

endmodule

`default_nettype wire

// ===== rtl/cosine_with_angle_mode.sv =====
// Top level of the pipelined cosine unit with degree/radian angle mode.
// Depends on cwam_pkg, cwam_reduce_step, cwam_convert, cwam_cordic_stage, cwam_finish.
//
//   channel   ports                               transfer
//   ------    ---------------------------------   ------------------------------
//   request   start, busy, req_angle              start high and busy low
//   response  rsp_strobe, rsp_cosine              one cycle per strobe, no hold-off
//   csr       csr_wr_en, csr_wr_data              every edge with csr_wr_en high, reset wins
//
// One angle is taken every cycle while busy is low. The pipe runs through the entry stage,
// the remainder chain of REDUCE_STEPS steps (one quotient bit per stage), the conversion
// stages, ROTATION_STAGES CORDIC stages (one rotation per stage) and the output stage.
// busy follows reset, so no transaction is taken during reset; reset clears all
// valid bits and sets degree mode. The receiver cannot stall, so neither does the pipe.
`default_nettype none

module cosine_with_angle_mode #(
   parameter int ROTATION_STAGES = cwam_pkg::ROTATION_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [cwam_pkg::ANGLE_W-1:0]  req_angle,
   output logic                                 rsp_strobe,
   output logic signed [cwam_pkg::RESULT_W-1:0] rsp_cosine,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data
);

   localparam int RSTEPS = cwam_pkg::REDUCE_STEPS;
   localparam int MW     = cwam_pkg::MAG_W;
   localparam int XW     = cwam_pkg::XY_W;
   localparam int ZW     = cwam_pkg::Z_W;
   localparam logic signed [XW-1:0] INV_GAIN_X = XW'(cwam_pkg::inv_gain(ROTATION_STAGES));

   logic degree_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         degree_mode_ff <= csr_wr_data;
      end
   end

   assign busy = reset;

   // entry stage: capture mode and angle magnitude (cosine is even)
   cwam_pkg::ctl_type entry_ctl_in, entry_ctl_ff;
   logic [MW-1:0]     entry_mag_in, entry_mag_ff;

   always_comb begin
      entry_ctl_in        = '0;
      entry_ctl_in.valid  = start && !busy;
      entry_ctl_in.degree = degree_mode_ff;
      entry_mag_in        = req_angle[cwam_pkg::ANGLE_W-1] ? MW'(-req_angle) : MW'(req_angle);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ctl_ff <= '0;
      end else begin
         entry_ctl_ff <= entry_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_mag_ff <= entry_mag_in;
   end

   // remainder chain, most significant quotient bit first
   cwam_pkg::ctl_type red_ctl [RSTEPS+1];
   logic [MW-1:0]     red_rem [RSTEPS+1];

   assign red_ctl[0] = entry_ctl_ff;
   assign red_rem[0] = entry_mag_ff;

   for (genvar i = 0; i < RSTEPS; i++) begin : g_reduce
      cwam_reduce_step #(.SHIFT(RSTEPS - 1 - i)) u_step (
         .clock   (clock),
         .reset   (reset),
         .in_ctl  (red_ctl[i]),
         .in_rem  (red_rem[i]),
         .out_ctl (red_ctl[i+1]),
         .out_rem (red_rem[i+1])
      );
   end

   cwam_pkg::ctl_type    conv_ctl;
   logic signed [ZW-1:0] conv_z;

   cwam_convert u_convert (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (red_ctl[RSTEPS]),
      .in_rem  (red_rem[RSTEPS]),
      .out_ctl (conv_ctl),
      .out_z   (conv_z)
   );

   cwam_pkg::ctl_type    cor_ctl [ROTATION_STAGES+1];
   logic signed [XW-1:0] cor_x   [ROTATION_STAGES+1];
   logic signed [XW-1:0] cor_y   [ROTATION_STAGES+1];
   logic signed [ZW-1:0] cor_z   [ROTATION_STAGES+1];

   assign cor_ctl[0] = conv_ctl;
   assign cor_x[0]   = INV_GAIN_X;
   assign cor_y[0]   = '0;
   assign cor_z[0]   = conv_z;

   for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cordic
      cwam_cordic_stage #(.IDX(i)) u_stage (
         .clock   (clock),
         .reset   (reset),
         .in_ctl  (cor_ctl[i]),
         .in_x    (cor_x[i]),
         .in_y    (cor_y[i]),
         .in_z    (cor_z[i]),
         .out_ctl (cor_ctl[i+1]),
         .out_x   (cor_x[i+1]),
         .out_y   (cor_y[i+1]),
         .out_z   (cor_z[i+1])
      );
   end

   cwam_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (cor_ctl[ROTATION_STAGES]),
      .in_x       (cor_x[ROTATION_STAGES]),
      .out_strobe (rsp_strobe),
      .out_cosine (rsp_cosine)
   );

endmodule

`default_nettype wire

// ===== rtl/cwam_checker.sv =====
// Port-level checks for the cosine unit, attached to the top level by bind.
// Depends on cwam_pkg and cosine_with_angle_mode.
`default_nettype none

module cwam_checker #(
   parameter int ROTATION_STAGES = cwam_pkg::ROTATION_STAGES_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic signed [cwam_pkg::ANGLE_W-1:0]  req_angle,
   input logic                                 rsp_strobe,
   input logic signed [cwam_pkg::RESULT_W-1:0] rsp_cosine,
   input logic                                 csr_wr_en,
   input logic                                 csr_wr_data
);

   localparam int LATENCY = cwam_pkg::REDUCE_STEPS + ROTATION_STAGES + 6;
   localparam logic signed [cwam_pkg::RESULT_W-1:0] ONE_Q =
      cwam_pkg::RESULT_W'(64'd1 << cwam_pkg::RESULT_FRAC_BITS);
   localparam logic signed [cwam_pkg::ANGLE_W-1:0] DEG90 =
      cwam_pkg::ANGLE_W'(cwam_pkg::DEG_Q1);

   logic mode_shadow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_shadow_ff <= 1'b1;
      end else if (csr_wr_en) begin
         mode_shadow_ff <= csr_wr_data;
      end
   end

   // pipeline is flushed by reset
   a_flush: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_cosine <= ONE_Q && rsp_cosine >= -ONE_Q))
      else $error("cosine outside [-1, 1]");

   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without a transaction at fixed latency");

   a_right_angle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && mode_shadow_ff && req_angle == DEG90)
         |-> ##LATENCY (rsp_strobe && rsp_cosine == '0))
      else $error("cos(90 deg) not exactly zero");

endmodule

bind cosine_with_angle_mode cwam_checker #(.ROTATION_STAGES(ROTATION_STAGES)) u_cwam_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_angle   (req_angle),
   .rsp_strobe  (rsp_strobe),
   .rsp_cosine  (rsp_cosine),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);

`default_nettype wire
